// ===== design/ttcd_pkg.sv =====
// package: constants, types and month tables for the tick to calendar date converter
`timescale 1ns / 1ps
package ttcd_pkg;

    localparam int DIV_STEP = 8;

    localparam int TICK_W  = 62;
    localparam int MSCNT_W = 49;
    localparam int SCNT_W  = 39;
    localparam int MCNT_W  = 33;
    localparam int HCNT_W  = 27;
    localparam int DAY_W   = 23;

    localparam int TICKS_PER_MS = 10000;
    localparam int MS_PER_SEC   = 1000;
    localparam int SEC_PER_MIN  = 60;
    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;
    localparam int DAYS_WEEK    = 7;
    localparam int DAYS_YEAR    = 365;
    localparam int DAYS_4Y      = DAYS_YEAR * 4 + 1;
    localparam int DAYS_100Y    = DAYS_4Y * 25 - 1;
    localparam int DAYS_400Y    = DAYS_100Y * 4 + 1;

    localparam logic [1:0] KIND_UNSPEC = 2'd0;
    localparam logic [1:0] KIND_UTC    = 2'd1;
    localparam logic [1:0] KIND_LOCAL  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] ms;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
    } t_tod;

    typedef logic [8:0] t_cum [12];

    localparam t_cum CUM_COMMON = '{9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
                                    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
    localparam t_cum CUM_LEAP   = '{9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
                                    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
        logic [8:0] v;
        v = '0;
        if (idx < 4'd12) begin
            v = leap ? CUM_LEAP[idx] : CUM_COMMON[idx];
        end
        return v;
    endfunction

endpackage

// ===== design/ttcd_cdiv.sv =====
// pipelined long division by a constant, STEP quotient bits per stage
`timescale 1ns / 1ps
module ttcd_cdiv
    import ttcd_pkg::*;
#(
    parameter int W    = 8,
    parameter int D    = 3,
    parameter int STEP = DIV_STEP,
    parameter int SW   = 1,
    localparam int RW  = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_valid,
    input  logic [W-1:0]  i_dividend,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_quot,
    output logic [RW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    localparam int NS = (W + STEP - 1) / STEP;
    localparam int PW = NS * STEP;
    localparam logic [RW:0] DV = (RW+1)'(D);

    logic          r_valid [NS];
    logic [PW-1:0] r_work  [NS];
    logic [RW-1:0] r_rem   [NS];
    logic [SW-1:0] r_side  [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [PW-1:0] w_in;
        logic [RW-1:0] rem_in;
        logic          v_in;
        logic [SW-1:0] side_in;
        logic [PW-1:0] n_work;
        logic [RW-1:0] n_rem;

        if (s == 0) begin : g_first
            assign w_in    = PW'(i_dividend);
            assign rem_in  = '0;
            assign v_in    = i_valid;
            assign side_in = i_side;
        end else begin : g_next
            assign w_in    = r_work[s-1];
            assign rem_in  = r_rem[s-1];
            assign v_in    = r_valid[s-1];
            assign side_in = r_side[s-1];
        end

        always_comb begin
            logic [RW:0]   acc;
            logic [PW-1:0] wk;
            logic [RW-1:0] rm;
            wk  = w_in;
            rm  = rem_in;
            acc = '0;
            for (int k = 0; k < STEP; k++) begin
                acc = {rm, wk[PW-1]};
                wk  = {wk[PW-2:0], 1'b0};
                if (acc >= DV) begin
                    acc   = acc - DV;
                    wk[0] = 1'b1;
                end
                rm = acc[RW-1:0];
            end
            n_work = wk;
            n_rem  = rm;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_ce) begin
                r_valid[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_work[s] <= n_work;
                r_rem[s]  <= n_rem;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_quot  = r_work[NS-1][W-1:0];
    assign o_rem   = r_rem[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

// ===== design/ttcd_date.sv =====
// day count to gregorian year, month, day and weekday
`timescale 1ns / 1ps
module ttcd_date
    import ttcd_pkg::*;
#(
    parameter int STEP = DIV_STEP
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  logic             i_valid,
    input  logic [DAY_W-1:0] i_days,
    input  t_tod             i_tod,
    output logic             o_valid,
    output t_tod             o_tod,
    output logic [13:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day_of_month,
    output logic [8:0]       o_day_of_year,
    output logic             o_leap_year,
    output logic [2:0]       o_weekday
);

    localparam int TW = $bits(t_tod);

    // weekday
    logic             wk_valid;
    logic [2:0]       wk_rem;
    logic [TW+DAY_W-1:0] wk_side;

    ttcd_cdiv #(.W(DAY_W), .D(DAYS_WEEK), .STEP(STEP), .SW(TW+DAY_W)) u_div7 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(i_ce), .i_valid(i_valid),
        .i_dividend(i_days), .i_side({i_tod, i_days}),
        .o_valid(wk_valid), .o_quot(), .o_rem(wk_rem), .o_side(wk_side)
    );

    // 400-year periods
    logic             c4_valid;
    logic [DAY_W-1:0] c4_quot;
    logic [17:0]      c4_rem;
    logic [TW+2:0]    c4_side;

    ttcd_cdiv #(.W(DAY_W), .D(DAYS_400Y), .STEP(STEP), .SW(TW+3)) u_div400 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(i_ce), .i_valid(wk_valid),
        .i_dividend(wk_side[DAY_W-1:0]), .i_side({wk_side[TW+DAY_W-1:DAY_W], wk_rem}),
        .o_valid(c4_valid), .o_quot(c4_quot), .o_rem(c4_rem), .o_side(c4_side)
    );

    // 100-year periods
    logic          c1_valid;
    logic [17:0]   c1_quot;
    logic [15:0]   c1_rem;
    logic [TW+8:0] c1_side;

    ttcd_cdiv #(.W(18), .D(DAYS_100Y), .STEP(STEP), .SW(TW+9)) u_div100 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(i_ce), .i_valid(c4_valid),
        .i_dividend(c4_rem), .i_side({c4_side, c4_quot[5:0]}),
        .o_valid(c1_valid), .o_quot(c1_quot), .o_rem(c1_rem), .o_side(c1_side)
    );

    // clamp last century
    logic           r_cl_valid;
    logic [1:0]     r_cl_q100;
    logic [16:0]    r_cl_rem;
    logic [TW+8:0]  r_cl_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl_valid <= 1'b0;
        end else if (i_ce) begin
            r_cl_valid <= c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cl_side <= c1_side;
            if (c1_quot[2]) begin
                r_cl_q100 <= 2'd3;
                r_cl_rem  <= {1'b0, c1_rem} + 17'(DAYS_100Y);
            end else begin
                r_cl_q100 <= c1_quot[1:0];
                r_cl_rem  <= {1'b0, c1_rem};
            end
        end
    end

    // 4-year periods
    logic           f4_valid;
    logic [16:0]    f4_quot;
    logic [10:0]    f4_rem;
    logic [TW+10:0] f4_side;

    ttcd_cdiv #(.W(17), .D(DAYS_4Y), .STEP(STEP), .SW(TW+11)) u_div4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(i_ce), .i_valid(r_cl_valid),
        .i_dividend(r_cl_rem), .i_side({r_cl_side, r_cl_q100}),
        .o_valid(f4_valid), .o_quot(f4_quot), .o_rem(f4_rem), .o_side(f4_side)
    );

    // single years
    logic           y1_valid;
    logic [10:0]    y1_quot;
    logic [8:0]     y1_rem;
    logic [TW+15:0] y1_side;

    ttcd_cdiv #(.W(11), .D(DAYS_YEAR), .STEP(STEP), .SW(TW+16)) u_div1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(i_ce), .i_valid(f4_valid),
        .i_dividend(f4_rem), .i_side({f4_side, f4_quot[4:0]}),
        .o_valid(y1_valid), .o_quot(y1_quot), .o_rem(y1_rem), .o_side(y1_side)
    );

    // clamp last year, leap flag
    logic        r_y_valid;
    t_tod        r_y_tod;
    logic [2:0]  r_y_wd;
    logic [5:0]  r_y_q400;
    logic [1:0]  r_y_q100;
    logic [4:0]  r_y_q4;
    logic [1:0]  r_y_q1;
    logic [8:0]  r_y_doy0;
    logic        r_y_leap;
    logic [1:0]  n_y_q1;

    assign n_y_q1 = y1_quot[2] ? 2'd3 : y1_quot[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_valid <= 1'b0;
        end else if (i_ce) begin
            r_y_valid <= y1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_y_tod  <= y1_side[TW+15:16];
            r_y_wd   <= y1_side[15:13];
            r_y_q400 <= y1_side[12:7];
            r_y_q100 <= y1_side[6:5];
            r_y_q4   <= y1_side[4:0];
            r_y_q1   <= n_y_q1;
            r_y_doy0 <= y1_quot[2] ? (y1_rem + 9'(DAYS_YEAR)) : y1_rem;
            r_y_leap <= (n_y_q1 == 2'd3) && ((y1_side[4:0] != 5'd24) || (y1_side[6:5] == 2'd3));
        end
    end

    // month lookup and year number
    logic [3:0]  n_mon;
    logic [8:0]  n_base;
    logic [13:0] n_year;

    always_comb begin
        n_mon = '0;
        for (int m = 0; m < 11; m++) begin
            if (r_y_doy0 >= cum_days(r_y_leap, 4'(m))) begin
                n_mon = n_mon + 4'd1;
            end
        end
        n_base = (n_mon == 4'd0) ? 9'd0 : cum_days(r_y_leap, n_mon - 4'd1);
        n_year = 14'(r_y_q400) * 14'd400 + 14'(r_y_q100) * 14'd100
               + 14'({r_y_q4, 2'b00}) + 14'(r_y_q1) + 14'd1;
    end

    logic        r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ce) begin
            r_o_valid <= r_y_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_tod          <= r_y_tod;
            o_weekday      <= r_y_wd;
            o_year         <= n_year;
            o_month        <= n_mon + 4'd1;
            o_day_of_month <= 5'(r_y_doy0 - n_base + 9'd1);
            o_day_of_year  <= r_y_doy0 + 9'd1;
            o_leap_year    <= r_y_leap;
        end
    end

    assign o_valid = r_o_valid;

endmodule

// ===== design/ticks_to_calendar_date.sv =====
// top level: 100 ns tick count to gregorian date and time of day
//
//   channel | valid    | stall    | payload
//   input   | i_valid  | o_stall  | i_tick_count, i_utc_flag, i_local_flag
//   output  | o_valid  | i_stall  | o_year .. o_time_kind
//
// one transfer per cycle in each direction unless stalled; the pipeline is the
// divider stages (ceil of width / P_DIV_STEP per constant divider) plus the
// century clamp, year clamp and output registers of ttcd_date, and holds while
// the output is stalled. reset clears only the valid bits of every stage.
`timescale 1ns / 1ps
module ticks_to_calendar_date
    import ttcd_pkg::*;
#(
    parameter int P_DIV_STEP = DIV_STEP
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [TICK_W-1:0] i_tick_count,
    input  logic              i_utc_flag,
    input  logic              i_local_flag,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [13:0]       o_year,
    output logic [3:0]        o_month,
    output logic [4:0]        o_day_of_month,
    output logic [8:0]        o_day_of_year,
    output logic              o_leap_year,
    output logic [2:0]        o_weekday,
    output logic [4:0]        o_hour,
    output logic [5:0]        o_minute,
    output logic [5:0]        o_second,
    output logic [9:0]        o_millisecond,
    output logic [1:0]        o_time_kind
);

    logic       ce;
    logic [1:0] in_kind;
    t_tod       tod_out;

    assign ce      = !(o_valid && i_stall);
    assign o_stall = !ce;
    assign in_kind = i_utc_flag ? KIND_UTC : (i_local_flag ? KIND_LOCAL : KIND_UNSPEC);

    logic               a_valid;
    logic [TICK_W-1:0]  a_quot;
    logic [1:0]         a_side;

    ttcd_cdiv #(.W(TICK_W), .D(TICKS_PER_MS), .STEP(P_DIV_STEP), .SW(2)) u_div_tick (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce), .i_valid(i_valid),
        .i_dividend(i_tick_count), .i_side(in_kind),
        .o_valid(a_valid), .o_quot(a_quot), .o_rem(), .o_side(a_side)
    );

    logic               b_valid;
    logic [MSCNT_W-1:0] b_quot;
    logic [9:0]         b_rem;
    logic [1:0]         b_side;

    ttcd_cdiv #(.W(MSCNT_W), .D(MS_PER_SEC), .STEP(P_DIV_STEP), .SW(2)) u_div_ms (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce), .i_valid(a_valid),
        .i_dividend(a_quot[MSCNT_W-1:0]), .i_side(a_side),
        .o_valid(b_valid), .o_quot(b_quot), .o_rem(b_rem), .o_side(b_side)
    );

    logic               c_valid;
    logic [SCNT_W-1:0]  c_quot;
    logic [5:0]         c_rem;
    logic [11:0]        c_side;

    ttcd_cdiv #(.W(SCNT_W), .D(SEC_PER_MIN), .STEP(P_DIV_STEP), .SW(12)) u_div_sec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce), .i_valid(b_valid),
        .i_dividend(b_quot[SCNT_W-1:0]), .i_side({b_side, b_rem}),
        .o_valid(c_valid), .o_quot(c_quot), .o_rem(c_rem), .o_side(c_side)
    );

    logic               d_valid;
    logic [MCNT_W-1:0]  d_quot;
    logic [5:0]         d_rem;
    logic [17:0]        d_side;

    ttcd_cdiv #(.W(MCNT_W), .D(MIN_PER_HOUR), .STEP(P_DIV_STEP), .SW(18)) u_div_min (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce), .i_valid(c_valid),
        .i_dividend(c_quot[MCNT_W-1:0]), .i_side({c_side, c_rem}),
        .o_valid(d_valid), .o_quot(d_quot), .o_rem(d_rem), .o_side(d_side)
    );

    logic               e_valid;
    logic [HCNT_W-1:0]  e_quot;
    logic [4:0]         e_rem;
    logic [23:0]        e_side;
    t_tod               e_tod;

    ttcd_cdiv #(.W(HCNT_W), .D(HOUR_PER_DAY), .STEP(P_DIV_STEP), .SW(24)) u_div_hour (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce), .i_valid(d_valid),
        .i_dividend(d_quot[HCNT_W-1:0]), .i_side({d_side, d_rem}),
        .o_valid(e_valid), .o_quot(e_quot), .o_rem(e_rem), .o_side(e_side)
    );

    assign e_tod = {e_side, e_rem};

    ttcd_date #(.STEP(P_DIV_STEP)) u_date (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce), .i_valid(e_valid),
        .i_days(e_quot[DAY_W-1:0]), .i_tod(e_tod),
        .o_valid(o_valid), .o_tod(tod_out),
        .o_year(o_year), .o_month(o_month), .o_day_of_month(o_day_of_month),
        .o_day_of_year(o_day_of_year), .o_leap_year(o_leap_year), .o_weekday(o_weekday)
    );

    assign o_hour        = tod_out.hour;
    assign o_minute      = tod_out.min;
    assign o_second      = tod_out.sec;
    assign o_millisecond = tod_out.ms;
    assign o_time_kind   = tod_out.kind;

endmodule
